// File: hdl/named_index_match_checker_unit_defines.svh
// ---------------------------------------------------------------------------
// Named index match checker: assertion macros
// Shared property wrappers; the including scope provides clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef NAMED_INDEX_MATCH_CHECKER_UNIT_DEFINES_SVH
`define NAMED_INDEX_MATCH_CHECKER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NIMC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold at every clock edge out of reset.
`define NIMC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// File: hdl/nimc_pkg.sv
// ---------------------------------------------------------------------------
// nimc_pkg
// Types, codes and name compare helpers for the named index match checker.
// ---------------------------------------------------------------------------
`default_nettype none

package nimc_pkg;

  localparam int NAME_BYTES  = 16;
  localparam int QUEUE_DEPTH = 2;

  // Command field codes; the fourth code carries no meaning and is dropped.
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_REQ   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ADD,
    OP_REQ
  } op_t;

  typedef enum logic [2:0] {
    STAT_FOUND    = 3'd0,
    STAT_SKIPPED  = 3'd1,
    STAT_MISSING  = 3'd2,
    STAT_MISMATCH = 3'd3,
    STAT_INVALID  = 3'd4,
    STAT_TOO_MANY = 3'd5,
    STAT_ABORTED  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  // One classified beat as it sits in the queue.
  typedef struct packed {
    op_t         op;
    logic [63:0] name_low;
    logic [63:0] name_high;
    logic [31:0] elems;
    logic        required;
    logic        no_zero;
  } item_t;

  // One stored index entry.
  typedef struct packed {
    logic [63:0] name_low;
    logic [63:0] name_high;
    logic [31:0] elems;
  } slot_t;

  function automatic logic has_zero_byte(logic [63:0] lo, logic [63:0] hi);
    logic [127:0] w;
    logic         z;
    w = {hi, lo};
    z = 1'b0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      z = z | (w[8*k +: 8] == 8'h00);
    end
    return z;
  endfunction

  // Equal up to and including the first zero byte, or in all bytes.
  function automatic logic names_equal(logic [63:0] a_lo, logic [63:0] a_hi,
                                       logic [63:0] b_lo, logic [63:0] b_hi);
    logic [127:0] a;
    logic [127:0] b;
    logic         stop;
    logic         eq;
    a    = {a_hi, a_lo};
    b    = {b_hi, b_lo};
    stop = 1'b0;
    eq   = 1'b1;
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (!stop) begin
        if (a[8*k +: 8] != b[8*k +: 8]) begin
          eq   = 1'b0;
          stop = 1'b1;
        end else if (a[8*k +: 8] == 8'h00) begin
          stop = 1'b1;
        end
      end
    end
    return eq;
  endfunction

endpackage

`default_nettype wire

// File: hdl/nimc_in_if.sv
// ---------------------------------------------------------------------------
// nimc_in_if
// Command channel: valid/ready handshake with one command beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface nimc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] name_low;
  logic [63:0] name_high;
  logic [31:0] elem_count;
  logic        is_required;

  modport source (
    output valid, command, name_low, name_high, elem_count, is_required,
    input  ready
  );
  modport sink (
    input  valid, command, name_low, name_high, elem_count, is_required,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/nimc_out_if.sv
// ---------------------------------------------------------------------------
// nimc_out_if
// Result channel: valid/ready handshake with one result beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface nimc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] match_slot;
  logic       batch_ok;

  modport source (
    output valid, status, match_slot, batch_ok,
    input  ready
  );
  modport sink (
    input  valid, status, match_slot, batch_ok,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/nimc_front.sv
// ---------------------------------------------------------------------------
// nimc_front
// Accept command beats, decode them and check names for a terminator.
// ---------------------------------------------------------------------------
`default_nettype none

module nimc_front (
  nimc_in_if.sink          in_ch,
  input  logic             q_full,
  output logic             push_valid,
  output nimc_pkg::item_t  push_item
);

  logic cmd_known;

  assign in_ch.ready = !q_full;

  always_comb begin
    push_item.name_low  = in_ch.name_low;
    push_item.name_high = in_ch.name_high;
    push_item.elems     = in_ch.elem_count;
    push_item.required  = in_ch.is_required;
    push_item.no_zero   = !nimc_pkg::has_zero_byte(in_ch.name_low, in_ch.name_high);
    cmd_known           = 1'b1;
    unique case (nimc_pkg::cmd_t'(in_ch.command))
      nimc_pkg::CMD_CLEAR: push_item.op = nimc_pkg::OP_CLEAR;
      nimc_pkg::CMD_ADD:   push_item.op = nimc_pkg::OP_ADD;
      nimc_pkg::CMD_REQ:   push_item.op = nimc_pkg::OP_REQ;
      default: begin
        // drop the unused code: take the beat, queue nothing
        push_item.op = nimc_pkg::OP_CLEAR;
        cmd_known    = 1'b0;
      end
    endcase
  end

  assign push_valid = in_ch.valid && !q_full && cmd_known;

endmodule

`default_nettype wire

// File: hdl/nimc_queue.sv
// ---------------------------------------------------------------------------
// nimc_queue
// Short FIFO of classified items between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module nimc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  nimc_pkg::item_t  push_item,
  output logic             q_full,
  output logic             q_valid,
  output nimc_pkg::item_t  q_item,
  input  logic             q_pop
);

  localparam int PTR_W = $clog2(nimc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(nimc_pkg::QUEUE_DEPTH + 1);

  nimc_pkg::item_t  q_mem [nimc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign q_full  = (count_r == CNT_W'(nimc_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = q_mem[rd_ptr_r];
  assign do_push = push_valid && !q_full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/nimc_back.sv
// ---------------------------------------------------------------------------
// nimc_back
// Execute queued items: scan the slot memory, update the index, post results.
// ---------------------------------------------------------------------------
`default_nettype none

module nimc_back #(
  parameter int MAX_SLOTS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  nimc_pkg::item_t  q_item,
  output logic             q_pop,
  nimc_out_if.source       out_ch
);

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int REQ_W  = $clog2(MAX_SLOTS + 2);

  nimc_pkg::state_t  state_r, state_nxt;
  nimc_pkg::item_t   op_r, op_nxt;
  logic [CNT_W-1:0]  entries_r, entries_nxt;
  logic [REQ_W-1:0]  req_seen_r, req_seen_nxt;
  logic              index_bad_r, index_bad_nxt;
  logic              failed_r, failed_nxt;
  logic [CNT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [SLOT_W-1:0] rd_idx_r;
  nimc_pkg::slot_t   rd_data_r;
  logic              found_r, found_nxt;
  logic [SLOT_W-1:0] hit_slot_r, hit_slot_nxt;
  logic [31:0]       hit_elems_r, hit_elems_nxt;
  nimc_pkg::status_t res_status_r, res_status_nxt;
  logic [2:0]        res_slot_r, res_slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  nimc_pkg::status_t out_status_r, out_status_nxt;
  logic [2:0]        out_slot_r, out_slot_nxt;
  logic              out_ok_r, out_ok_nxt;

  nimc_pkg::slot_t   slot_mem [MAX_SLOTS];
  logic              wr_en;
  logic [SLOT_W-1:0] rd_addr;
  logic              issue;
  logic              out_free;
  logic              res_fail;

  assign issue    = (state_r == nimc_pkg::S_SCAN) && (scan_idx_r < entries_r);
  assign rd_addr  = scan_idx_r[SLOT_W-1:0];
  assign out_free = !out_valid_r || out_ch.ready;
  assign res_fail = (res_status_r == nimc_pkg::STAT_MISSING)  ||
                    (res_status_r == nimc_pkg::STAT_MISMATCH) ||
                    (res_status_r == nimc_pkg::STAT_INVALID)  ||
                    (res_status_r == nimc_pkg::STAT_TOO_MANY);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.match_slot = out_slot_r;
  assign out_ch.batch_ok   = out_ok_r;

  // Slot memory: one write, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[entries_r[SLOT_W-1:0]] <= '{name_low:  op_r.name_low,
                                           name_high: op_r.name_high,
                                           elems:     op_r.elems};
    end
    rd_data_r <= slot_mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    entries_nxt    = entries_r;
    req_seen_nxt   = req_seen_r;
    index_bad_nxt  = index_bad_r;
    failed_nxt     = failed_r;
    scan_idx_nxt   = scan_idx_r;
    rd_vld_nxt     = 1'b0;
    found_nxt      = found_r;
    hit_slot_nxt   = hit_slot_r;
    hit_elems_nxt  = hit_elems_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_ok_nxt     = out_ok_r;
    q_pop          = 1'b0;
    wr_en          = 1'b0;

    unique case (state_r)
      nimc_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          op_nxt       = q_item;
          scan_idx_nxt = '0;
          found_nxt    = 1'b0;
          res_slot_nxt = 3'd0;
          unique case (q_item.op)
            nimc_pkg::OP_CLEAR: begin
              entries_nxt   = '0;
              req_seen_nxt  = '0;
              index_bad_nxt = 1'b0;
              failed_nxt    = 1'b0;
            end
            nimc_pkg::OP_ADD: begin
              if (entries_r == CNT_W'(MAX_SLOTS)) begin
                index_bad_nxt = 1'b1;
              end else begin
                index_bad_nxt = index_bad_r | q_item.no_zero;
                state_nxt     = nimc_pkg::S_SCAN;
              end
            end
            nimc_pkg::OP_REQ: begin
              if (req_seen_r <= REQ_W'(MAX_SLOTS)) begin
                req_seen_nxt = req_seen_r + REQ_W'(1);
              end
              priority if (failed_r) begin
                res_status_nxt = nimc_pkg::STAT_ABORTED;
                state_nxt      = nimc_pkg::S_RESULT;
              end else if (index_bad_r) begin
                res_status_nxt = nimc_pkg::STAT_INVALID;
                state_nxt      = nimc_pkg::S_RESULT;
              end else if (req_seen_nxt > REQ_W'(MAX_SLOTS)) begin
                res_status_nxt = nimc_pkg::STAT_TOO_MANY;
                state_nxt      = nimc_pkg::S_RESULT;
              end else begin
                state_nxt      = nimc_pkg::S_SCAN;
              end
            end
            default: begin
              state_nxt = nimc_pkg::S_IDLE;
            end
          endcase
        end
      end

      nimc_pkg::S_SCAN: begin
        if (issue) begin
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
          rd_vld_nxt   = 1'b1;
        end
        // later slots overwrite earlier hits: highest match wins
        if (rd_vld_r && nimc_pkg::names_equal(rd_data_r.name_low, rd_data_r.name_high,
                                              op_r.name_low, op_r.name_high)) begin
          found_nxt     = 1'b1;
          hit_slot_nxt  = rd_idx_r;
          hit_elems_nxt = rd_data_r.elems;
        end
        if (!issue && !rd_vld_r) begin
          if (op_r.op == nimc_pkg::OP_ADD) begin
            wr_en         = 1'b1;
            index_bad_nxt = index_bad_r | found_r;
            entries_nxt   = entries_r + CNT_W'(1);
            state_nxt     = nimc_pkg::S_IDLE;
          end else begin
            priority if (!found_r) begin
              res_status_nxt = op_r.required ? nimc_pkg::STAT_MISSING
                                             : nimc_pkg::STAT_SKIPPED;
              res_slot_nxt   = 3'd0;
            end else if (hit_elems_r != op_r.elems) begin
              res_status_nxt = nimc_pkg::STAT_MISMATCH;
              res_slot_nxt   = 3'(hit_slot_r);
            end else begin
              res_status_nxt = nimc_pkg::STAT_FOUND;
              res_slot_nxt   = 3'(hit_slot_r);
            end
            state_nxt = nimc_pkg::S_RESULT;
          end
        end
      end

      nimc_pkg::S_RESULT: begin
        if (out_free) begin
          failed_nxt     = failed_r | res_fail;
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_ok_nxt     = !(failed_r | res_fail);
          state_nxt      = nimc_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = nimc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nimc_pkg::S_IDLE;
      entries_r   <= '0;
      req_seen_r  <= '0;
      index_bad_r <= 1'b0;
      failed_r    <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      entries_r   <= entries_nxt;
      req_seen_r  <= req_seen_nxt;
      index_bad_r <= index_bad_nxt;
      failed_r    <= failed_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    scan_idx_r   <= scan_idx_nxt;
    rd_idx_r     <= rd_addr;
    found_r      <= found_nxt;
    hit_slot_r   <= hit_slot_nxt;
    hit_elems_r  <= hit_elems_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_ok_r     <= out_ok_nxt;
  end

endmodule

`default_nettype wire

// File: hdl/named_index_match_checker_unit.sv
// ---------------------------------------------------------------------------
// named_index_match_checker_unit
// Index of named entries with request lookup and batch failure tracking.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries command beats: clear (empty index, reset flags), add entry
//   (store name and element count) or request (look a name up). Clear and add
//   produce no result; every request produces exactly one beat on out_ch with
//   status, match_slot and batch_ok. The unused command code is taken and
//   dropped.
//   A front end decodes each beat into a two-entry queue, so in_ch keeps
//   accepting while the back end works or out_ch is stalled; in_ch.ready
//   drops only when the queue is full.
//   The back end handles one item at a time and walks the slot memory one
//   slot per cycle (one read port). An add to a non-full index scans every
//   held entry, then writes its slot; a request scans every held entry,
//   then posts its result. A clear, or a request decided by the batch flags,
//   skips the scan.
//   If out_ch stalls, the result is held in the output register and the
//   next request waits in the back end before posting its own.
//   Reset (synchronous, active low) empties the index, clears the counters
//   and flags, and drops queued items; slot memory is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

`include "named_index_match_checker_unit_defines.svh"

module named_index_match_checker_unit #(
  parameter int MAX_SLOTS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  nimc_in_if.sink    in_ch,
  nimc_out_if.source out_ch
);

  // Front to queue: decoded item and its push strobe.
  logic            push_valid;
  nimc_pkg::item_t push_item;
  logic            q_full;

  // Queue to back end.
  logic            q_valid;
  nimc_pkg::item_t q_item;
  logic            q_pop;

  // Result beat classification for the checks below.
  logic            out_found;
  logic            out_failed;
  logic            out_slot_ok;

  // Decode beats and check names for a terminator; hold off when full.
  nimc_front u_front (
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  // Decouple accept from execution.
  nimc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .q_full     (q_full),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // Scan slots, update index state, post one result per request.
  nimc_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  assign out_found   = out_ch.valid && (out_ch.status == nimc_pkg::STAT_FOUND);
  assign out_failed  = out_ch.valid &&
                       ((out_ch.status == nimc_pkg::STAT_MISSING)  ||
                        (out_ch.status == nimc_pkg::STAT_MISMATCH) ||
                        (out_ch.status == nimc_pkg::STAT_INVALID)  ||
                        (out_ch.status == nimc_pkg::STAT_TOO_MANY) ||
                        (out_ch.status == nimc_pkg::STAT_ABORTED));
  assign out_slot_ok = !out_ch.valid ||
                       (out_ch.status == nimc_pkg::STAT_FOUND) ||
                       (out_ch.status == nimc_pkg::STAT_MISMATCH) ||
                       (out_ch.match_slot == 3'd0);

  // A found result never comes with a failed batch.
  `NIMC_ASSERT_SAME(a_found_ok, out_found, out_ch.batch_ok, "found result reports failed batch")

  // Failing statuses always report a failed batch.
  `NIMC_ASSERT_SAME(a_fail_not_ok, out_failed, !out_ch.batch_ok, "failing status with good batch")

  // Slot is zero unless an entry matched.
  `NIMC_ASSERT_ALWAYS(a_slot_zero, out_slot_ok, "nonzero slot without a match")

endmodule

`default_nettype wire

// File: tb/named_index_match_checker_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// named_index_match_checker_unit_test
// Self-checking bench for the named index match checker. Command beats are
// queued up front (a directed opening, then random batches of clear, add and
// request), sent by a clocked driver and mirrored into an index model as they
// are accepted. Each request's predicted status, slot and batch flag is
// compared against the result channel, in order, while both channel ends
// idle at random.
// ---------------------------------------------------------------------------

module named_index_match_checker_unit_test;

  localparam int         MAX_ENTRIES  = 8;
  localparam int         RANDOM_BEATS = 1800;
  localparam int         DRAIN_CYCLES = 40;
  // The fourth command code has no enum member; the block takes and drops it.
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  typedef struct packed {
    logic [1:0]   command;
    logic [127:0] name;     // {name_high, name_low}
    logic [31:0]  elem_count;
    logic         is_required;
  } index_cmd_t;

  typedef struct packed {
    nimc_pkg::status_t status;
    logic [2:0]        slot;
    logic              batch_ok;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst_n;

  nimc_in_if  in_ch ();
  nimc_out_if out_ch ();

  named_index_match_checker_unit #(
    .MAX_SLOTS(MAX_ENTRIES)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  // Beats waiting to be sent, and the lookups the index model says are due.
  index_cmd_t     cmd_backlog[$];
  lookup_result_t pending_lookups[$];

  int beats_total;
  int beats_sent;
  int beats_accepted;
  int mismatches;
  int tx_idle_pct;
  int rx_idle_pct;

  // Index model state.
  logic [127:0] model_names[MAX_ENTRIES];
  logic [31:0]  model_elems[MAX_ENTRIES];
  int           model_entries;
  int           model_requests;
  logic         model_index_bad;
  logic         model_batch_failed;

  // -------------------------------------------------------------------------
  // Name helpers
  // -------------------------------------------------------------------------

  // Compare as strncmp over 16 bytes: stop at the first zero byte.
  function automatic logic same_name(logic [127:0] a, logic [127:0] b);
    for (int k = 0; k < 16; k++) begin
      if (a[8*k +: 8] != b[8*k +: 8]) return 1'b0;
      if (a[8*k +: 8] == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic logic terminated(logic [127:0] n);
    for (int k = 0; k < 16; k++) begin
      if (n[8*k +: 8] == 8'h00) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Nonzero bytes before term_at, a zero at term_at, noise after it.
  // term_at of 16 yields a name with no terminator at all.
  function automatic logic [127:0] random_name(int term_at);
    logic [127:0] n;
    for (int k = 0; k < 16; k++) begin
      if (k < term_at) n[8*k +: 8] = 8'($urandom_range(1, 255));
      else if (k == term_at) n[8*k +: 8] = 8'h00;
      else n[8*k +: 8] = 8'($urandom_range(0, 255));
    end
    return n;
  endfunction

  // Reroll everything past the terminator: the name still compares equal.
  function automatic logic [127:0] rescramble_tail(logic [127:0] n);
    logic         past;
    logic [127:0] r;
    past = 1'b0;
    r    = n;
    for (int k = 0; k < 16; k++) begin
      if (past) r[8*k +: 8] = 8'($urandom_range(0, 255));
      if (n[8*k +: 8] == 8'h00) past = 1'b1;
    end
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Index model: apply one accepted beat, queue the lookup it answers with
  // -------------------------------------------------------------------------
  task automatic apply_index_command(input index_cmd_t c);
    lookup_result_t r;
    int             hit;
    case (c.command)
      nimc_pkg::CMD_CLEAR: begin
        model_entries      = 0;
        model_requests     = 0;
        model_index_bad    = 1'b0;
        model_batch_failed = 1'b0;
      end
      nimc_pkg::CMD_ADD: begin
        if (model_entries >= MAX_ENTRIES) begin
          // Full index: flag it and drop the entry.
          model_index_bad = 1'b1;
        end else begin
          if (!terminated(c.name)) model_index_bad = 1'b1;
          for (int i = 0; i < model_entries; i++) begin
            if (same_name(model_names[i], c.name)) model_index_bad = 1'b1;
          end
          model_names[model_entries] = c.name;
          model_elems[model_entries] = c.elem_count;
          model_entries++;
        end
      end
      nimc_pkg::CMD_REQ: begin
        // The request counter saturates one past the slot count.
        if (model_requests <= MAX_ENTRIES) model_requests++;
        r.slot = 3'd0;
        if (model_batch_failed) begin
          r.status = nimc_pkg::STAT_ABORTED;
        end else if (model_index_bad) begin
          r.status = nimc_pkg::STAT_INVALID;
        end else if (model_requests > MAX_ENTRIES) begin
          r.status = nimc_pkg::STAT_TOO_MANY;
        end else begin
          // Highest matching slot wins.
          hit = -1;
          for (int i = 0; i < model_entries; i++) begin
            if (same_name(model_names[i], c.name)) hit = i;
          end
          if (hit < 0) begin
            r.status = c.is_required ? nimc_pkg::STAT_MISSING : nimc_pkg::STAT_SKIPPED;
          end else begin
            r.slot   = 3'(hit);
            r.status = (model_elems[hit] == c.elem_count) ? nimc_pkg::STAT_FOUND
                                                          : nimc_pkg::STAT_MISMATCH;
          end
        end
        if (r.status inside {nimc_pkg::STAT_MISSING, nimc_pkg::STAT_MISMATCH,
                             nimc_pkg::STAT_INVALID, nimc_pkg::STAT_TOO_MANY})
          model_batch_failed = 1'b1;
        r.batch_ok = !model_batch_failed;
        pending_lookups.push_back(r);
      end
      default: ;  // unused code: no effect
    endcase
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  task automatic queue_beat(input logic [1:0] command, input logic [127:0] name,
                            input logic [31:0] elem_count, input logic is_required);
    index_cmd_t c;
    c.command     = command;
    c.name        = name;
    c.elem_count  = elem_count;
    c.is_required = is_required;
    cmd_backlog.push_back(c);
  endtask

  task automatic build_stimulus();
    logic [127:0] batch_names[$];
    logic [31:0]  batch_elems[$];
    logic [127:0] name;
    logic [31:0]  count;
    int           real_beats;
    int           n_add;
    int           n_req;
    int           pick;
    logic         clash;

    // Directed opening. Requests on an empty index: optional skips,
    // required fails, then the batch is aborted.
    queue_beat(nimc_pkg::CMD_REQ, random_name(3), 32'd7, 1'b0);
    queue_beat(nimc_pkg::CMD_REQ, random_name(5), 32'd7, 1'b1);
    queue_beat(nimc_pkg::CMD_REQ, random_name(2), 32'd7, 1'b0);
    queue_beat(CMD_UNUSED, {128{1'b1}}, 32'hFFFF_FFFF, 1'b1);
    queue_beat(nimc_pkg::CMD_CLEAR, {128{1'b1}}, 32'hFFFF_FFFF, 1'b1);
    // Empty name with zero count, and a 15-byte name of all ones.
    queue_beat(nimc_pkg::CMD_ADD, 128'd0, 32'd0, 1'b0);
    queue_beat(nimc_pkg::CMD_ADD, {64'h00FF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
               32'hFFFF_FFFF, 1'b0);
    queue_beat(nimc_pkg::CMD_REQ, {64'h00FF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
               32'hFFFF_FFFF, 1'b1);
    // Empty name with noise after its terminator still hits slot zero.
    queue_beat(nimc_pkg::CMD_REQ, {64'hA5A5_5A5A_C3C3_3C3C, 64'h5A5A_A5A5_3C3C_C300},
               32'd0, 1'b1);
    // Count mismatch on a hit.
    queue_beat(nimc_pkg::CMD_REQ, {64'h00FF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
               32'd0, 1'b0);
    // Unterminated name breaks the index.
    queue_beat(nimc_pkg::CMD_CLEAR, 128'd0, 32'd0, 1'b0);
    queue_beat(nimc_pkg::CMD_ADD, {128{1'b1}}, 32'd3, 1'b0);
    queue_beat(nimc_pkg::CMD_REQ, {128{1'b1}}, 32'd3, 1'b1);
    // Duplicate under strncmp rules breaks the index.
    queue_beat(nimc_pkg::CMD_CLEAR, 128'd0, 32'd0, 1'b0);
    queue_beat(nimc_pkg::CMD_ADD, {64'd0, 64'h0000_0000_0000_4241}, 32'd1, 1'b0);
    queue_beat(nimc_pkg::CMD_ADD, {64'h1234_5678_9ABC_DEF0, 64'hDEAD_BEEF_0000_4241},
               32'd2, 1'b0);
    queue_beat(nimc_pkg::CMD_REQ, {64'd0, 64'h0000_0000_0000_4241}, 32'd1, 1'b0);
    // One request past the slot count, then an aborted one.
    queue_beat(nimc_pkg::CMD_CLEAR, 128'd0, 32'd0, 1'b0);
    for (int i = 0; i < MAX_ENTRIES + 2; i++) begin
      queue_beat(nimc_pkg::CMD_REQ, random_name($urandom_range(0, 15)), $urandom, 1'b0);
    end

    // Random batches: mostly clean indexes with hits, some broken ones.
    real_beats = 0;
    while (real_beats < RANDOM_BEATS) begin
      queue_beat(nimc_pkg::CMD_CLEAR, {$urandom, $urandom, $urandom, $urandom}, $urandom,
                 1'($urandom));
      real_beats++;
      batch_names.delete();
      batch_elems.delete();
      n_add = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, MAX_ENTRIES);
      for (int a = 0; a < n_add; a++) begin
        do begin
          name  = random_name($urandom_range(0, 15));
          clash = 1'b0;
          foreach (batch_names[j]) if (same_name(batch_names[j], name)) clash = 1'b1;
        end while (clash);
        count = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 4)) : $urandom;
        batch_names.push_back(name);
        batch_elems.push_back(count);
        queue_beat(nimc_pkg::CMD_ADD, name, count, 1'($urandom));
        real_beats++;
      end

      // Break roughly one batch in eight.
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0: begin
            name = (batch_names.size() != 0) ?
                   rescramble_tail(batch_names[$urandom_range(0, batch_names.size() - 1)]) :
                   random_name(16);
            queue_beat(nimc_pkg::CMD_ADD, name, $urandom, 1'($urandom));
            real_beats++;
          end
          1: begin
            queue_beat(nimc_pkg::CMD_ADD, random_name(16), $urandom, 1'($urandom));
            real_beats++;
          end
          default: begin
            // Overfill the index.
            for (int a = batch_names.size(); a <= MAX_ENTRIES; a++) begin
              queue_beat(nimc_pkg::CMD_ADD, random_name($urandom_range(0, 15)), $urandom,
                         1'($urandom));
              real_beats++;
            end
          end
        endcase
      end

      n_req = ($urandom_range(0, 5) == 0) ? $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 3) :
                                            $urandom_range(1, MAX_ENTRIES);
      for (int q = 0; q < n_req; q++) begin
        if (batch_names.size() != 0 && $urandom_range(0, 9) < 7) begin
          pick  = $urandom_range(0, batch_names.size() - 1);
          name  = $urandom_range(0, 1) ? rescramble_tail(batch_names[pick]) : batch_names[pick];
          count = ($urandom_range(0, 9) < 8) ? batch_elems[pick] : $urandom;
        end else begin
          name  = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom, $urandom, $urandom} :
                                                random_name($urandom_range(0, 15));
          count = $urandom;
        end
        queue_beat(nimc_pkg::CMD_REQ, name, count, 1'($urandom));
        real_beats++;
      end

      // Noise: the unused code, and fully random beats.
      if ($urandom_range(0, 19) == 0)
        queue_beat(CMD_UNUSED, {$urandom, $urandom, $urandom, $urandom}, $urandom, 1'($urandom));
      if ($urandom_range(0, 19) == 0) begin
        queue_beat(2'($urandom_range(0, 3)), {$urandom, $urandom, $urandom, $urandom},
                   $urandom, 1'($urandom));
        real_beats++;
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Driver: change inputs on the falling edge
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    index_cmd_t nxt;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      // Three idle phases by progress: sparse receiver, then sparse sender,
      // then full throughput.
      case ((beats_sent * 3) / beats_total)
        0:       begin tx_idle_pct = 7;  rx_idle_pct = 48; end
        1:       begin tx_idle_pct = 48; rx_idle_pct = 7;  end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      // Hold the current beat until it is taken; only then advance.
      if (!in_ch.valid || beats_accepted == beats_sent) begin
        if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          nxt                = cmd_backlog.pop_front();
          in_ch.command     <= nxt.command;
          in_ch.name_low    <= nxt.name[63:0];
          in_ch.name_high   <= nxt.name[127:64];
          in_ch.elem_count  <= nxt.elem_count;
          in_ch.is_required <= nxt.is_required;
          in_ch.valid       <= 1'b1;
          beats_sent++;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: sample both channels on the rising edge
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    index_cmd_t     seen;
    lookup_result_t due;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.command     = in_ch.command;
        seen.name        = {in_ch.name_high, in_ch.name_low};
        seen.elem_count  = in_ch.elem_count;
        seen.is_required = in_ch.is_required;
        apply_index_command(seen);
        beats_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_lookups.size() == 0) begin
          $display("%0t: result expected none actual status %0d slot %0d batch_ok %0b",
                   $time, out_ch.status, out_ch.match_slot, out_ch.batch_ok);
          mismatches++;
        end else begin
          due = pending_lookups.pop_front();
          if (out_ch.status !== due.status) begin
            $display("%0t: status expected %0d actual %0d", $time, due.status, out_ch.status);
            mismatches++;
          end
          if (out_ch.match_slot !== due.slot) begin
            $display("%0t: match_slot expected %0d actual %0d",
                     $time, due.slot, out_ch.match_slot);
            mismatches++;
          end
          if (out_ch.batch_ok !== due.batch_ok) begin
            $display("%0t: batch_ok expected %0b actual %0b",
                     $time, due.batch_ok, out_ch.batch_ok);
            mismatches++;
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sequence: fill the backlog, reset, wait for the drain, report
  // -------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.command      = nimc_pkg::CMD_CLEAR;
    in_ch.name_low     = 64'd0;
    in_ch.name_high    = 64'd0;
    in_ch.elem_count   = 32'd0;
    in_ch.is_required  = 1'b0;
    out_ch.ready       = 1'b0;
    beats_sent         = 0;
    beats_accepted     = 0;
    mismatches         = 0;
    tx_idle_pct        = 0;
    rx_idle_pct        = 0;
    model_entries      = 0;
    model_requests     = 0;
    model_index_bad    = 1'b0;
    model_batch_failed = 1'b0;

    build_stimulus();
    beats_total = cmd_backlog.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until every beat is taken and every lookup has come back.
    while (beats_accepted < beats_total || pending_lookups.size() != 0) @(posedge clk);
    // Leave room for a stray result after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("named_index_match_checker_unit_test OK");
    end else begin
      $display("named_index_match_checker_unit_test NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #800000;
    $display("named_index_match_checker_unit_test NOT OK");
    $finish;
  end

endmodule
